FILE: rtl/dbc_pkg.sv
// Shared types, constants and codeword helpers of the dictionary bitmask decompressor.
package dbc_pkg;

  localparam int WORD_BITS    = 32;
  localparam int DICT_ENTRIES = 16;
  localparam int IDX_BITS     = $clog2(DICT_ENTRIES);
  localparam int LEFT_BITS    = 34;                      // longest incomplete codeword
  localparam int BUF_BITS     = LEFT_BITS + WORD_BITS;   // leftover plus one stream word
  localparam int CNT_W        = $clog2(BUF_BITS + 1);
  localparam int MAX_RESULTS  = 64;
  localparam int RES_W        = $clog2(MAX_RESULTS + 1);
  localparam int LEN_W        = 6;
  localparam int IN_TDATA_W   = 40;                      // dict_index + data_word, byte padded

  // Codeword formats (first three bits of a codeword)
  typedef enum logic [2:0] {
    FMT_RAW   = 3'b000,
    FMT_RPT   = 3'b001,
    FMT_MASK  = 3'b010,
    FMT_FLIP1 = 3'b011,
    FMT_FLIP2 = 3'b100,
    FMT_FLIP4 = 3'b101,
    FMT_TWO   = 3'b110,
    FMT_DICT  = 3'b111
  } fmt_t;

  typedef enum logic {
    KIND_LOAD   = 1'b0,
    KIND_STREAM = 1'b1
  } item_kind_t;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_DECODE = 1'b1
  } bk_state_t;

  typedef struct packed {
    item_kind_t            kind;
    logic [IDX_BITS-1:0]   idx;
    logic [WORD_BITS-1:0]  data;
    logic                  last;
  } item_t;

  // Head of the queue as seen by the back part
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  // Length in bits of a whole codeword
  function automatic logic [LEN_W-1:0] code_len(input fmt_t f);
    logic [LEN_W-1:0] len;
    unique case (f)
      FMT_RAW:   len = LEN_W'(35);
      FMT_RPT:   len = LEN_W'(6);
      FMT_MASK:  len = LEN_W'(16);
      FMT_FLIP1: len = LEN_W'(12);
      FMT_FLIP2: len = LEN_W'(12);
      FMT_FLIP4: len = LEN_W'(12);
      FMT_TWO:   len = LEN_W'(17);
      FMT_DICT:  len = LEN_W'(7);
      default:   len = LEN_W'(7);
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/dbc_front.sv
// Front part: accepts input transfers, classifies them and queues them for the back part.
module dbc_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dbc_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  logic                           in_tlast,
  output dbc_pkg::q_head_t               head,
  input  logic                           pop
);
  import dbc_pkg::*;

  item_t      q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       do_pop;
  item_t      new_item;

  // Classify the incoming transfer
  always_comb begin
    new_item.kind = in_tuser ? KIND_STREAM : KIND_LOAD;
    new_item.idx  = in_tdata[IDX_BITS-1:0];
    new_item.data = in_tdata[IDX_BITS +: WORD_BITS];
    new_item.last = in_tlast;
  end

  assign in_tready  = (count_r != 2'd2);
  assign push       = in_tvalid && in_tready;
  assign do_pop     = pop && (count_r != 2'd0);
  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the queued items
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

FILE: rtl/dbc_back.sv
// Back part: dictionary, bit buffer, stallable codeword decoder and result register.
module dbc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dbc_pkg::q_head_t              head,
  output logic                          pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dbc_pkg::WORD_BITS-1:0] out_tdata,
  output logic                          out_tlast
);
  import dbc_pkg::*;

  logic [WORD_BITS-1:0] dict_r [DICT_ENTRIES];
  logic                 dict_we;

  bk_state_t            state_r, state_nxt;
  logic [BUF_BITS-1:0]  buf_r, buf_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0] prev_r, prev_nxt;
  logic                 final_r, final_nxt;
  logic [RES_W-1:0]     res_cnt_r, res_cnt_nxt;
  logic [2:0]           rep_r, rep_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic [WORD_BITS-1:0] pend_data_r, pend_data_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [WORD_BITS-1:0] out_data_r, out_data_nxt;
  logic                 out_last_r, out_last_nxt;

  fmt_t                 fmt;
  logic [LEN_W-1:0]     len;
  logic                 have_code;
  logic [4:0]           loc;
  logic [4:0]           loc2;
  logic [IDX_BITS-1:0]  idx;
  logic [WORD_BITS-1:0] entry;
  logic [WORD_BITS-1:0] flip_mask;
  logic [WORD_BITS-1:0] result;
  logic                 out_free;
  logic                 res_full;
  logic                 can_produce;
  logic                 push;
  logic                 push_last;

  // Pick apart the codeword at the head of the buffer
  assign fmt       = fmt_t'(buf_r[BUF_BITS-1 -: 3]);
  assign len       = code_len(fmt);
  assign have_code = (cnt_r >= CNT_W'(3)) && (cnt_r >= CNT_W'(len));
  assign loc       = buf_r[BUF_BITS-4 -: 5];
  assign loc2      = buf_r[BUF_BITS-9 -: 5];

  always_comb begin
    unique case (fmt)
      FMT_MASK: idx = buf_r[BUF_BITS-13 -: IDX_BITS];
      FMT_TWO:  idx = buf_r[BUF_BITS-14 -: IDX_BITS];
      FMT_DICT: idx = buf_r[BUF_BITS-4 -: IDX_BITS];
      default:  idx = buf_r[BUF_BITS-9 -: IDX_BITS];
    endcase
  end

  assign entry = dict_r[idx];

  // Build the flip pattern; bits pushed past the word end drop out
  always_comb begin
    unique case (fmt)
      FMT_MASK:  flip_mask = {buf_r[BUF_BITS-9 -: 4], 28'd0} >> loc;
      FMT_FLIP1: flip_mask = {4'b1000, 28'd0} >> loc;
      FMT_FLIP2: flip_mask = {4'b1100, 28'd0} >> loc;
      FMT_FLIP4: flip_mask = {4'b1111, 28'd0} >> loc;
      FMT_TWO:   flip_mask = ({1'b1, 31'd0} >> loc) ^ ({1'b1, 31'd0} >> loc2);
      default:   flip_mask = '0;
    endcase
  end

  always_comb begin
    unique case (fmt)
      FMT_RAW: result = buf_r[BUF_BITS-4 -: WORD_BITS];
      FMT_RPT: result = prev_r;
      default: result = entry ^ flip_mask;
    endcase
  end

  assign out_free    = !out_valid_r || out_tready;
  assign res_full    = (res_cnt_r == RES_W'(MAX_RESULTS));
  assign can_produce = res_full || !pend_valid_r || out_free;

  // Sequence items and codewords
  always_comb begin
    state_nxt      = state_r;
    buf_nxt        = buf_r;
    cnt_nxt        = cnt_r;
    prev_nxt       = prev_r;
    final_nxt      = final_r;
    res_cnt_nxt    = res_cnt_r;
    rep_nxt        = rep_r;
    pend_valid_nxt = pend_valid_r;
    pend_data_nxt  = pend_data_r;
    pop            = 1'b0;
    dict_we        = 1'b0;
    push           = 1'b0;
    push_last      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.kind == KIND_LOAD) begin
            dict_we = 1'b1;
          end else begin
            // Append the stream word behind the leftover bits
            buf_nxt     = buf_r | ({head.item.data, LEFT_BITS'(0)} >> cnt_r);
            cnt_nxt     = cnt_r + CNT_W'(WORD_BITS);
            final_nxt   = head.item.last;
            res_cnt_nxt = '0;
            rep_nxt     = '0;
            state_nxt   = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        if (!have_code) begin
          // Close the item: release the held result marked as last
          if (!pend_valid_r || out_free) begin
            push           = pend_valid_r;
            push_last      = 1'b1;
            pend_valid_nxt = 1'b0;
            if (final_r) begin
              buf_nxt = '0;
              cnt_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end
        end else if (can_produce) begin
          prev_nxt = result;
          if (!res_full) begin
            res_cnt_nxt    = res_cnt_r + RES_W'(1);
            pend_valid_nxt = 1'b1;
            pend_data_nxt  = result;
            push           = pend_valid_r;
          end
          if (fmt == FMT_RPT && rep_r != buf_r[BUF_BITS-4 -: 3]) begin
            rep_nxt = rep_r + 3'd1;
          end else begin
            // Drop the finished codeword
            rep_nxt = '0;
            buf_nxt = buf_r << len;
            cnt_nxt = cnt_r - CNT_W'(len);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = pend_data_r;
      out_last_nxt  = push_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      buf_r        <= '0;
      cnt_r        <= '0;
      prev_r       <= '0;
      final_r      <= 1'b0;
      res_cnt_r    <= '0;
      rep_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      buf_r        <= buf_nxt;
      cnt_r        <= cnt_nxt;
      prev_r       <= prev_nxt;
      final_r      <= final_nxt;
      res_cnt_r    <= res_cnt_nxt;
      rep_r        <= rep_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers and dictionary
  always_ff @(posedge clk) begin
    pend_data_r <= pend_data_nxt;
    out_data_r  <= out_data_nxt;
    out_last_r  <= out_last_nxt;
    if (dict_we) begin
      dict_r[head.item.idx] <= head.item.data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/dictionary_bitmask_code_decompressor.sv
// Top level of the dictionary bitmask code decompressor.
//
//   Channel  Direction  Ports                     Contents
//   in_      slave      tvalid tready tdata       dict_index [3:0], data_word [35:4]
//                       tuser tlast               tuser: operation, tlast: last_word
//   out_     master     tvalid tready tdata       instruction [31:0]
//                       tlast                     last result of an input item
//
// A load item writes the dictionary in the back part; a stream word is merged into the bit
// buffer, decoded codeword by codeword while the output is free (a repeat codeword gives
// its result n+1 times) and closed; the next item waits for that. Reset is
// synchronous and clears the queue, bit buffer and previous instruction; dictionary contents
// are kept unknown. A stalled output holds the decoder; a two-entry queue buffers input.
module dictionary_bitmask_code_decompressor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dbc_pkg::IN_TDATA_W-1:0] in_tdata,   // dict_index, data_word, zero pad
  input  logic                           in_tuser,   // operation
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [dbc_pkg::WORD_BITS-1:0]  out_tdata,  // instruction
  output logic                           out_tlast
);
  import dbc_pkg::*;

  q_head_t head;
  logic    pop;

  dbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .head      (head),
    .pop       (pop)
  );

  dbc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/dbc_checker.sv
// Port-level checks of the decompressor and their bind to the top level.
module dbc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [dbc_pkg::WORD_BITS-1:0] out_tdata,
  input logic                          out_tlast
);
  import dbc_pkg::*;

  // A stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Reset empties the result register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Reset empties the queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

  // The queue only fills on a transfer
  a_ready_keep: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && !in_tvalid |=> in_tready)
    else $error("input ready dropped without a transfer");

endmodule

bind dictionary_bitmask_code_decompressor dbc_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
